/* hw/rtl/fracadd_pkg.sv */
// ---------------------------------------------------------------------------
// Fraction add and reduce package
// Widths, shared types and the sequencer and divider states for the fraction adder.
// ---------------------------------------------------------------------------
package fracadd_pkg;

   // Width of an input numerator; denominators are one bit narrower.
   localparam int IN_WIDTH   = 32;
   localparam int DEN_WIDTH  = IN_WIDTH - 1;
   // Full product width and the magnitude width of any cross term.
   localparam int PROD_WIDTH = 2 * IN_WIDTH;
   localparam int MAG_WIDTH  = PROD_WIDTH - 1;
   localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);
   // Fixed widths of the result fields.
   localparam int SUM_NUM_WIDTH = 64;
   localparam int SUM_DEN_WIDTH = 63;

   // Operands of one input item.
   typedef struct packed {
      logic signed [IN_WIDTH-1:0] first_num;
      logic [DEN_WIDTH-1:0]       first_den;
      logic signed [IN_WIDTH-1:0] second_num;
      logic [DEN_WIDTH-1:0]       second_den;
   } fracadd_op_type;

   // Status and result of the sequencer toward the channel logic.
   typedef struct packed {
      logic                            idle;
      logic                            done;
      logic signed [SUM_NUM_WIDTH-1:0] sum_num;
      logic signed [SUM_DEN_WIDTH-1:0] sum_den;
   } fracadd_stat_type;

   // Request to the shared shift-subtract divider.
   typedef struct packed {
      logic                 start;
      logic [MAG_WIDTH-1:0] dividend;
      logic [MAG_WIDTH-1:0] divisor;
   } fracadd_divreq_type;

   // Answer from the shared shift-subtract divider.
   typedef struct packed {
      logic                 done;
      logic [MAG_WIDTH-1:0] quotient;
      logic [MAG_WIDTH-1:0] remainder;
   } fracadd_divrsp_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_UP,
      DIV_DOWN,
      DIV_DONE
   } fracadd_div_state_type;

   typedef enum logic [3:0] {
      CTRL_IDLE,
      CTRL_MUL_A,
      CTRL_MUL_B,
      CTRL_MUL_D,
      CTRL_SETUP,
      CTRL_EUC_CHECK,
      CTRL_EUC_WAIT,
      CTRL_QN_WAIT,
      CTRL_QD_START,
      CTRL_QD_WAIT,
      CTRL_HOLD
   } fracadd_ctrl_state_type;

endpackage

/* hw/rtl/fracadd_if.sv */
// ---------------------------------------------------------------------------
// Fraction add and reduce channels
// Valid/ready channels for the operand items and the result items.
// ---------------------------------------------------------------------------
interface fracadd_req_if;
   import fracadd_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [IN_WIDTH-1:0]  first_numerator;
   logic [DEN_WIDTH-1:0]        first_denominator;
   logic signed [IN_WIDTH-1:0]  second_numerator;
   logic [DEN_WIDTH-1:0]        second_denominator;

   modport source (
      output valid, first_numerator, first_denominator,
      output second_numerator, second_denominator,
      input  ready
   );
   modport sink (
      input  valid, first_numerator, first_denominator,
      input  second_numerator, second_denominator,
      output ready
   );
endinterface

interface fracadd_rsp_if;
   import fracadd_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [SUM_NUM_WIDTH-1:0] sum_numerator;
   logic signed [SUM_DEN_WIDTH-1:0] sum_denominator;

   modport source (
      output valid, sum_numerator, sum_denominator,
      input  ready
   );
   modport sink (
      input  valid, sum_numerator, sum_denominator,
      output ready
   );
endinterface

/* hw/rtl/fraction_add_reduce.sv */
// ---------------------------------------------------------------------------
// Fraction add and reduce
// Adds two fractions and returns the sum reduced by its gcd.
// ---------------------------------------------------------------------------
// Usage: an item on req_chan carries two fractions, each a signed numerator
// over a positive denominator. One result item appears on rsp_chan with the
// reduced numerator and denominator; a negative gcd flips both signs, and a
// zero sum gives 0/1.
// Steps: the MUL_A, MUL_B and MUL_D states form the cross products and the
// SETUP state sets up the magnitudes. Then the gcd loop and two reducing
// divisions run on one shared shift-subtract divider; each division aligns
// the divisor and then forms its quotient bits. The HOLD state hands the
// result to the output register.
// Throughput: one item at a time; req_chan.ready is high only while the
// sequencer is idle, and the divider's one-bit-per-cycle loop sets the rate.
// The result sits in an output register, so the next item is accepted while
// an earlier result waits. When the receiver stalls with that register full,
// the sequencer holds its finished result until the register frees up.
// Reset is synchronous and returns the block to idle with no result pending.
// ---------------------------------------------------------------------------
module fraction_add_reduce (
   input logic          clock,
   input logic          reset,
   fracadd_req_if.sink   req_chan,
   fracadd_rsp_if.source rsp_chan
);
   import fracadd_pkg::*;

   fracadd_op_type                  op;
   fracadd_stat_type                stat;
   fracadd_divreq_type              div_req;
   fracadd_divrsp_type              div_rsp;
   logic                            start;
   logic                            take;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_NUM_WIDTH-1:0] rsp_num_ff, rsp_num_in;
   logic signed [SUM_DEN_WIDTH-1:0] rsp_den_ff, rsp_den_in;

   // Input side: accept an item whenever the sequencer is idle.
   assign req_chan.ready = stat.idle;
   assign start          = req_chan.valid & req_chan.ready;
   assign op.first_num   = req_chan.first_numerator;
   assign op.first_den   = req_chan.first_denominator;
   assign op.second_num  = req_chan.second_numerator;
   assign op.second_den  = req_chan.second_denominator;

   fracadd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .op      (op),
      .take    (take),
      .stat    (stat),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fracadd_divu u_divu (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output register: load a finished result when it is empty or draining.
   assign take         = stat.done & (~rsp_valid_ff | rsp_chan.ready);
   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_chan.ready);
   assign rsp_num_in   = take ? stat.sum_num : rsp_num_ff;
   assign rsp_den_in   = take ? stat.sum_den : rsp_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sum_numerator   = rsp_num_ff;
   assign rsp_chan.sum_denominator = rsp_den_ff;

   // An accepted item keeps the sequencer busy on the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_chan.ready)
      else $error("sequencer still ready after accepting an item");

   // A handed-over result is always presented on the next cycle.
   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_chan.valid)
      else $error("result handed over but not presented");

   // A zero numerator only comes with a denominator of one or zero.
   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.sum_numerator == '0) |->
         (rsp_chan.sum_denominator == SUM_DEN_WIDTH'(1) ||
          rsp_chan.sum_denominator == '0))
      else $error("zero sum not reduced to 0/1");

endmodule

/* hw/rtl/fracadd_divu.sv */
// ---------------------------------------------------------------------------
// Fraction adder shift-subtract divider
// Unsigned magnitude divider shared by the gcd loop and the two reducing divisions.
// ---------------------------------------------------------------------------
module fracadd_divu (
   input  logic                            clock,
   input  logic                            reset,
   input  fracadd_pkg::fracadd_divreq_type div_req,
   output fracadd_pkg::fracadd_divrsp_type div_rsp
);
   import fracadd_pkg::*;

   fracadd_div_state_type state_ff, state_in;
   logic [MAG_WIDTH-1:0]  rem_ff, rem_in;
   logic [MAG_WIDTH:0]    sh_ff, sh_in;
   logic [MAG_WIDTH-1:0]  quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [MAG_WIDTH:0]    cmp_op;
   logic [MAG_WIDTH:0]    diff;
   logic                  fits;

   // One comparator: doubled divisor while aligning, divisor while subtracting.
   assign cmp_op = (state_ff == DIV_UP) ? {sh_ff[MAG_WIDTH-1:0], 1'b0} : sh_ff;
   assign fits   = cmp_op <= {1'b0, rem_ff};
   assign diff   = {1'b0, rem_ff} - sh_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) state_in = DIV_UP;
         end
         DIV_UP: begin
            if (!fits) state_in = DIV_DOWN;
         end
         DIV_DOWN: begin
            if (cnt_ff == '0) state_in = DIV_DONE;
         end
         DIV_DONE: begin
            state_in = div_req.start ? DIV_UP : DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   // Datapath updates and outputs.
   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      div_rsp.done      = (state_ff == DIV_DONE);
      div_rsp.quotient  = quo_ff;
      div_rsp.remainder = rem_ff;
      unique case (state_ff)
         DIV_IDLE, DIV_DONE: begin
            if (div_req.start) begin
               rem_in = div_req.dividend;
               sh_in  = {1'b0, div_req.divisor};
               quo_in = '0;
               cnt_in = '0;
            end
         end
         DIV_UP: begin
            // Shift the divisor up until it just fits below the dividend.
            if (fits) begin
               sh_in  = {sh_ff[MAG_WIDTH-1:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         DIV_DOWN: begin
            // One quotient bit per cycle, most significant first.
            if (fits) rem_in = diff[MAG_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], fits};
            if (cnt_ff != '0) begin
               sh_in  = {1'b0, sh_ff[MAG_WIDTH:1]};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* hw/rtl/fracadd_ctrl.sv */
// ---------------------------------------------------------------------------
// Fraction adder sequencer
// Forms the cross products, runs the gcd loop and the reducing divisions.
// ---------------------------------------------------------------------------
module fracadd_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  fracadd_pkg::fracadd_op_type     op,
   input  logic                            take,
   output fracadd_pkg::fracadd_stat_type   stat,
   output fracadd_pkg::fracadd_divreq_type div_req,
   input  fracadd_pkg::fracadd_divrsp_type div_rsp
);
   import fracadd_pkg::*;

   fracadd_ctrl_state_type          state_ff, state_in;
   fracadd_op_type                  op_ff, op_in;
   logic signed [PROD_WIDTH-1:0]    prod_ff, prod_in;
   logic signed [PROD_WIDTH-1:0]    num_ff, num_in;
   logic [MAG_WIDTH-1:0]            nmag_ff, nmag_in;
   logic [MAG_WIDTH-1:0]            den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]            m_ff, m_in;
   logic [MAG_WIDTH-1:0]            k_ff, k_in;
   logic                            mpar_ff, mpar_in;
   logic [MAG_WIDTH-1:0]            g_ff, g_in;
   logic                            gneg_ff, gneg_in;
   logic [MAG_WIDTH-1:0]            qn_ff, qn_in;
   logic signed [SUM_NUM_WIDTH-1:0] res_num_ff, res_num_in;
   logic signed [SUM_DEN_WIDTH-1:0] res_den_ff, res_den_in;
   logic signed [IN_WIDTH-1:0]      mul_x, mul_y;
   logic signed [PROD_WIDTH-1:0]    mul_p;
   logic signed [IN_WIDTH-1:0]      b1_ext, b2_ext;
   logic [PROD_WIDTH-1:0]           num_abs;
   logic [SUM_NUM_WIDTH-1:0]        qn_wide;
   logic [SUM_DEN_WIDTH-1:0]        qd_wide;

   // Denominators are positive, so they enter the multiplier zero extended.
   assign b1_ext  = signed'({1'b0, op_ff.first_den});
   assign b2_ext  = signed'({1'b0, op_ff.second_den});
   assign mul_p   = mul_x * mul_y;
   assign num_abs = num_ff[PROD_WIDTH-1] ? -num_ff : num_ff;
   assign qn_wide = SUM_NUM_WIDTH'(qn_ff);
   assign qd_wide = SUM_DEN_WIDTH'(div_rsp.quotient);

   assign stat.idle    = (state_ff == CTRL_IDLE);
   assign stat.done    = (state_ff == CTRL_HOLD);
   assign stat.sum_num = res_num_ff;
   assign stat.sum_den = res_den_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE:  if (start) state_in = CTRL_MUL_A;
         CTRL_MUL_A: state_in = CTRL_MUL_B;
         CTRL_MUL_B: state_in = CTRL_MUL_D;
         CTRL_MUL_D: state_in = CTRL_SETUP;
         CTRL_SETUP: state_in = CTRL_EUC_CHECK;
         CTRL_EUC_CHECK: begin
            priority if (k_ff != '0) state_in = CTRL_EUC_WAIT;
            else if (m_ff == '0)     state_in = CTRL_HOLD;
            else                     state_in = CTRL_QN_WAIT;
         end
         CTRL_EUC_WAIT: if (div_rsp.done) state_in = CTRL_EUC_CHECK;
         CTRL_QN_WAIT:  if (div_rsp.done) state_in = CTRL_QD_START;
         CTRL_QD_START: state_in = CTRL_QD_WAIT;
         CTRL_QD_WAIT:  if (div_rsp.done) state_in = CTRL_HOLD;
         CTRL_HOLD:     if (take) state_in = CTRL_IDLE;
         default:       state_in = CTRL_IDLE;
      endcase
   end

   // Datapath control for each step.
   always_comb begin
      op_in      = op_ff;
      prod_in    = prod_ff;
      num_in     = num_ff;
      nmag_in    = nmag_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      m_in       = m_ff;
      k_in       = k_ff;
      mpar_in    = mpar_ff;
      g_in       = g_ff;
      gneg_in    = gneg_ff;
      qn_in      = qn_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      mul_x      = op_ff.first_num;
      mul_y      = b2_ext;
      div_req    = '0;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (start) op_in = op;
         end
         CTRL_MUL_A: begin
            prod_in = mul_p;
         end
         CTRL_MUL_B: begin
            mul_x   = op_ff.second_num;
            mul_y   = b1_ext;
            prod_in = mul_p;
            num_in  = prod_ff;
         end
         CTRL_MUL_D: begin
            mul_x   = b1_ext;
            mul_y   = b2_ext;
            prod_in = mul_p;
            num_in  = num_ff + prod_ff;
         end
         CTRL_SETUP: begin
            // Work on magnitudes; the sign of each term follows its index.
            den_in  = prod_ff[MAG_WIDTH-1:0];
            neg_in  = num_ff[PROD_WIDTH-1];
            nmag_in = num_abs[MAG_WIDTH-1:0];
            m_in    = num_abs[MAG_WIDTH-1:0];
            k_in    = prod_ff[MAG_WIDTH-1:0];
            mpar_in = 1'b0;
         end
         CTRL_EUC_CHECK: begin
            if (k_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = m_ff;
               div_req.divisor  = k_ff;
            end else begin
               // Terms at even places carry the numerator's sign.
               g_in    = m_ff;
               gneg_in = neg_ff & ~mpar_ff;
               if (m_ff == '0) begin
                  res_num_in = '0;
                  res_den_in = '0;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = nmag_ff;
                  div_req.divisor  = m_ff;
               end
            end
         end
         CTRL_EUC_WAIT: begin
            if (div_rsp.done) begin
               m_in    = k_ff;
               k_in    = div_rsp.remainder;
               mpar_in = ~mpar_ff;
            end
         end
         CTRL_QN_WAIT: begin
            if (div_rsp.done) qn_in = div_rsp.quotient;
         end
         CTRL_QD_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = den_ff;
            div_req.divisor  = g_ff;
         end
         CTRL_QD_WAIT: begin
            if (div_rsp.done) begin
               res_num_in = (neg_ff ^ gneg_ff) ? -signed'(qn_wide) : signed'(qn_wide);
               res_den_in = gneg_ff ? -signed'(qd_wide) : signed'(qd_wide);
            end
         end
         CTRL_HOLD: begin
            div_req = '0;
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      nmag_ff    <= nmag_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      m_ff       <= m_in;
      k_ff       <= k_in;
      mpar_ff    <= mpar_in;
      g_ff       <= g_in;
      gneg_ff    <= gneg_in;
      qn_ff      <= qn_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
   end

endmodule
